@@ rtl/uelm_pkg.sv @@
// shared types and constants for the line envelope core
package uelm_pkg;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_DOMINATED  = 3'd1,
    ST_SLOPE_DEC  = 3'd2,
    ST_FULL       = 3'd3,
    ST_QUERY_OK   = 3'd4,
    ST_QUERY_EMPTY = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOP_RD,
    S_TOP_CHK,
    S_POP_RD,
    S_POP_MUL,
    S_POP_CMP,
    S_PUSH,
    S_Q_RD,
    S_Q_MUL,
    S_Q_CMP,
    S_Q_EVAL,
    S_Q_SUM,
    S_DONE
  } fsm_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

@@ rtl/uelm_ram.sv @@
// generic single-port-write, single-read ram with registered read data
module uelm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/upper_envelope_line_max_core.sv @@
// top level of the upper-envelope line store with maximum queries
// usage
//   one item channel: raise start with in_op and the payload while busy is
//   low; the item is taken at that edge and busy rises on the next cycle.
//   insert (in_op 0) adds the line in_slope*x+in_intercept, popping lines
//   it makes useless; query (in_op 1) returns the largest line value at
//   in_query_x. every item yields one result: out_valid is high for one
//   cycle with out_value and out_status, and the receiver cannot stall it.
// flow
//   lines live in one ram (slope and intercept side by side), read data
//   registered. an insert reads and checks the top line, runs pop tests
//   (ram read, two products, compare) and writes the line; an equal slope
//   replacing a top with a line below rereads the new top first. a query
//   runs at most ceil(log2 n) search steps, then evaluates the line found;
//   an empty query skips the search. the single ram read port and single
//   33x33 multiplier serialise these steps. busy is low in the out_valid
//   cycle, so the next item can be taken then.
// reset
//   rst_n low empties the store (count to zero) and returns to idle; ram
//   contents are left as they are and only entries below the count are read.
module upper_envelope_line_max_core
  import uelm_pkg::*;
#(
  parameter int MAX_LINES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic signed [31:0] in_slope,
  input  logic signed [31:0] in_intercept,
  input  logic signed [31:0] in_query_x,
  output logic               out_valid,
  output logic signed [63:0] out_value,
  output logic [2:0]         out_status
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_LINES);

  fsm_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] keep_r, keep_nxt;   // lines kept during an insert
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;

  logic signed [31:0] a_r, b_r, x_r;

  // top line held across pops (line keep-1)
  logic signed [31:0] ta_r, ta_nxt, tb_r, tb_nxt;
  // line below the top
  logic signed [31:0] la_r, la_nxt, lb_r, lb_nxt;

  // products
  logic signed [65:0] p0_r, p0_nxt, p1_r, p1_nxt;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_y;

  logic signed [63:0] val_r, val_nxt;
  status_t            st_r, st_nxt;
  logic               ov_r, ov_nxt;
  logic               step_r, step_nxt;   // first or second product

  // ram
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic signed [31:0] rd_a, rd_b;

  uelm_ram #(.WIDTH(64), .DEPTH(MAX_LINES)) u_lines (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_a = rdata[63:32];
  assign rd_b = rdata[31:0];

  assign mul_y = mul_a * mul_b;

  logic [CW-1:0] mid;
  assign mid = CW'((({1'b0, lo_r} + {1'b0, hi_r}) >> 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      a_r  <= in_slope;
      b_r  <= in_intercept;
      x_r  <= in_query_x;
    end
    keep_r <= keep_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    ta_r   <= ta_nxt;
    tb_r   <= tb_nxt;
    la_r   <= la_nxt;
    lb_r   <= lb_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    val_r  <= val_nxt;
    st_r   <= st_nxt;
    step_r <= step_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = ov_r;
  assign out_value  = val_r;
  assign out_status = st_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    keep_nxt  = keep_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ta_nxt    = ta_r;
    tb_nxt    = tb_r;
    la_nxt    = la_r;
    lb_nxt    = lb_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    step_nxt  = step_r;
    ov_nxt    = 1'b0;
    we        = 1'b0;
    waddr     = keep_r[AW-1:0];
    wdata     = {a_r, b_r};
    raddr     = '0;
    mul_a     = '0;
    mul_b     = '0;

    unique case (state_r)
      S_IDLE: begin
        keep_nxt = count_r;
        step_nxt = 1'b0;
        raddr    = AW'(count_r - CW'(1));
        if (start) begin
          if (in_op == OP_QUERY) begin
            if (count_r == '0) begin
              val_nxt   = '0;
              st_nxt    = ST_QUERY_EMPTY;
              state_nxt = S_DONE;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = count_r - CW'(1);
              state_nxt = S_Q_RD;
            end
          end else if (count_r == '0) begin
            state_nxt = S_PUSH;
          end else begin
            state_nxt = S_TOP_RD;
          end
        end
      end

      // ram output now holds the top line
      S_TOP_RD: begin
        ta_nxt    = rd_a;
        tb_nxt    = rd_b;
        state_nxt = S_TOP_CHK;
      end

      S_TOP_CHK: begin
        val_nxt = '0;
        if (a_r < ta_r) begin
          st_nxt    = ST_SLOPE_DEC;
          state_nxt = S_DONE;
        end else if (a_r == ta_r && b_r <= tb_r) begin
          st_nxt    = ST_DOMINATED;
          state_nxt = S_DONE;
        end else if (a_r == ta_r) begin
          // replace the top: drop it, next top is line keep-2
          keep_nxt  = keep_r - CW'(1);
          raddr     = AW'(keep_r - CW'(2));
          state_nxt = (keep_r >= CW'(2)) ? S_POP_RD : S_PUSH;
          if (keep_r >= CW'(2)) begin
            state_nxt = S_TOP_RD;
          end
          // need fresh top read, reuse top states
          raddr = AW'(keep_r - CW'(2));
        end else if (keep_r >= CW'(2)) begin
          raddr     = AW'(keep_r - CW'(2));
          state_nxt = S_POP_RD;
        end else begin
          state_nxt = S_PUSH;
        end
      end

      // ram holds line keep-2
      S_POP_RD: begin
        la_nxt    = rd_a;
        lb_nxt    = rd_b;
        step_nxt  = 1'b0;
        state_nxt = S_POP_MUL;
      end

      // (b1-b)*(a2-a1) then (b1-b2)*(a-a1)
      S_POP_MUL: begin
        if (!step_r) begin
          mul_a    = 33'(lb_r) - 33'(b_r);
          mul_b    = 33'(ta_r) - 33'(la_r);
          p0_nxt   = mul_y;
          step_nxt = 1'b1;
        end else begin
          mul_a     = 33'(lb_r) - 33'(tb_r);
          mul_b     = 33'(a_r) - 33'(la_r);
          p1_nxt    = mul_y;
          state_nxt = S_POP_CMP;
        end
      end

      S_POP_CMP: begin
        if (p0_r <= p1_r) begin
          // pop the top; the line below becomes top
          keep_nxt = keep_r - CW'(1);
          ta_nxt   = la_r;
          tb_nxt   = lb_r;
          raddr    = AW'(keep_r - CW'(3));
          state_nxt = (keep_r >= CW'(3)) ? S_POP_RD : S_PUSH;
        end else begin
          state_nxt = S_PUSH;
        end
      end

      S_PUSH: begin
        val_nxt = '0;
        if (keep_r >= FULL_CNT) begin
          st_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = keep_r + CW'(1);
          st_nxt    = ST_INSERTED;
        end
        state_nxt = S_DONE;
      end

      S_Q_RD: begin
        if (lo_r < hi_r) begin
          raddr     = AW'(mid);
          state_nxt = S_Q_MUL;
          step_nxt  = 1'b0;
        end else begin
          raddr     = AW'(lo_r);
          state_nxt = S_Q_EVAL;
        end
      end

      // line mid latched first; then line mid+1 arrives
      S_Q_MUL: begin
        if (!step_r) begin
          la_nxt   = rd_a;
          lb_nxt   = rd_b;
          raddr    = AW'(mid + CW'(1));
          step_nxt = 1'b1;
        end else begin
          mul_a     = 33'(x_r);
          mul_b     = 33'(rd_a) - 33'(la_r);
          p0_nxt    = mul_y;
          p1_nxt    = 66'(lb_r) - 66'(rd_b);
          state_nxt = S_Q_CMP;
        end
      end

      S_Q_CMP: begin
        if (p0_r <= p1_r) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + CW'(1);
        end
        state_nxt = S_Q_RD;
      end

      S_Q_EVAL: begin
        la_nxt    = rd_a;
        lb_nxt    = rd_b;
        state_nxt = S_Q_SUM;
        step_nxt  = 1'b0;
      end

      S_Q_SUM: begin
        if (!step_r) begin
          mul_a    = 33'(la_r);
          mul_b    = 33'(x_r);
          p0_nxt   = mul_y;
          step_nxt = 1'b1;
        end else begin
          val_nxt   = 64'(p0_r + 66'(lb_r));
          st_nxt    = ST_QUERY_OK;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ tb/upper_envelope_line_max_core_test.sv @@
// self-checking testbench for the upper-envelope line store core
module upper_envelope_line_max_core_test
  import uelm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LINES = 1024;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 700;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_op;
  logic signed [31:0] in_slope;
  logic signed [31:0] in_intercept;
  logic signed [31:0] in_query_x;
  logic               out_valid;
  logic signed [63:0] out_value;
  logic [2:0]         out_status;

  upper_envelope_line_max_core #(.MAX_LINES(MAX_LINES)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_slope(in_slope), .in_intercept(in_intercept),
    .in_query_x(in_query_x), .out_valid(out_valid), .out_value(out_value),
    .out_status(out_status)
  );

  // one expected result per accepted item
  typedef struct {
    logic signed [63:0] value;
    status_t            status;
  } envelope_result_t;

  envelope_result_t pending_results[$];
  int               mismatches;
  int               cycle_count = 0;

  // predictor's own copy of the line stack
  longint hull_slope[MAX_LINES];
  longint hull_icpt[MAX_LINES];
  int     hull_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit guards against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL upper_envelope_line_max_core");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // exact sign-safe product compare, operands widened so nothing overflows
  function automatic logic prod_le(input longint p, input longint q,
                                   input longint r, input longint s);
    logic signed [71:0] wp, wq, wr, ws;
    wp = p; wq = q; wr = r; ws = s;
    return (wp * wq) <= (wr * ws);
  endfunction

  // insert a line on the envelope stack, returns the status it earns
  function automatic status_t hull_insert(input longint a, input longint b);
    int keep;
    keep = hull_count;
    if (keep > 0) begin
      if (a < hull_slope[keep-1]) return ST_SLOPE_DEC;
      if (a == hull_slope[keep-1]) begin
        if (b <= hull_icpt[keep-1]) return ST_DOMINATED;
        keep--;
      end
    end
    // drop top lines whose breakpoint the new line overtakes
    while (keep >= 2) begin
      if (prod_le(hull_icpt[keep-2] - b, hull_slope[keep-1] - hull_slope[keep-2],
                  hull_icpt[keep-2] - hull_icpt[keep-1], a - hull_slope[keep-2]))
        keep--;
      else
        break;
    end
    if (keep >= MAX_LINES) return ST_FULL;
    hull_slope[keep] = a;
    hull_icpt[keep]  = b;
    hull_count = keep + 1;
    return ST_INSERTED;
  endfunction

  // binary search over breakpoints for the best line at x
  function automatic logic signed [63:0] hull_max_at(input longint x);
    int lo, hi, mid;
    logic signed [71:0] lhs, d, num;
    lo = 0;
    hi = hull_count - 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      d   = hull_slope[mid+1] - hull_slope[mid];
      num = hull_icpt[mid] - hull_icpt[mid+1];
      lhs = x;
      lhs = lhs * d;
      if (lhs <= num) hi = mid;
      else lo = mid + 1;
    end
    return hull_slope[lo] * x + hull_icpt[lo];
  endfunction

  function automatic envelope_result_t predict_item(input logic op,
      input logic signed [31:0] a, input logic signed [31:0] b,
      input logic signed [31:0] x);
    envelope_result_t r;
    r.value = '0;
    if (op == OP_INSERT) r.status = hull_insert(a, b);
    else if (hull_count == 0) r.status = ST_QUERY_EMPTY;
    else begin
      r.value  = hull_max_at(x);
      r.status = ST_QUERY_OK;
    end
    return r;
  endfunction

  // present one item, hold it until taken, then log what it must produce
  task automatic send_item(input logic op, input logic signed [31:0] a,
                           input logic signed [31:0] b, input logic signed [31:0] x,
                           input logic fixed, input envelope_result_t typed);
    envelope_result_t r;
    int gap;
    gap = $urandom_range(0, 3);
    // start was dropped at the previous accepting edge
    repeat (gap + 1) @(posedge clk);
    start        <= 1'b1;
    in_op        <= op;
    in_slope     <= a;
    in_intercept <= b;
    in_query_x   <= x;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    r = predict_item(op, a, b, x);
    if (fixed && (r.value !== typed.value || r.status !== typed.status))
      report("typed expectation disagrees with predictor");
    if (fixed) r = typed;
    pending_results = {pending_results, r};
  endtask

  // every strobe must match the oldest waiting expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) report("result with nothing expected");
      else begin
        envelope_result_t e;
        e = pending_results.pop_front();
        if (out_status !== e.status)
          report($sformatf("status %0d, wanted %0d", out_status, e.status));
        if (out_value !== e.value)
          report($sformatf("value %0d, wanted %0d", out_value, e.value));
      end
    end
  end

  // directed rows: op, slope, intercept, x, typed?, value, status
  typedef struct {
    logic               op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] x;
    logic               fixed;
    logic signed [63:0] value;
    status_t            status;
  } directed_row_t;

  directed_row_t directed_rows[14] = '{
    '{OP_QUERY,  0,      0,      S_MAX, 1'b1, 64'sd0, ST_QUERY_EMPTY},
    '{OP_INSERT, S_MIN,  0,      0,     1'b1, 64'sd0, ST_INSERTED},
    '{OP_INSERT, S_MIN,  -5,     0,     1'b1, 64'sd0, ST_DOMINATED},
    '{OP_INSERT, S_MIN,  S_MAX,  0,     1'b1, 64'sd0, ST_INSERTED},
    '{OP_QUERY,  0,      0,      0,     1'b1, 64'sd2147483647, ST_QUERY_OK},
    '{OP_QUERY,  0,      0,      S_MIN, 1'b0, 64'sd0, ST_QUERY_OK},
    '{OP_QUERY,  0,      0,      S_MAX, 1'b0, 64'sd0, ST_QUERY_OK},
    '{OP_INSERT, -100,   S_MIN,  0,     1'b0, 64'sd0, ST_INSERTED},
    '{OP_INSERT, -200,   7,      0,     1'b1, 64'sd0, ST_SLOPE_DEC},
    '{OP_INSERT, -50,    S_MIN,  0,     1'b0, 64'sd0, ST_INSERTED},
    '{OP_INSERT, -10,    1000,   0,     1'b0, 64'sd0, ST_INSERTED},
    '{OP_QUERY,  0,      0,      -1,    1'b0, 64'sd0, ST_QUERY_OK},
    '{OP_QUERY,  0,      0,      1,     1'b0, 64'sd0, ST_QUERY_OK},
    '{OP_QUERY,  0,      0,      12345, 1'b0, 64'sd0, ST_QUERY_OK}
  };

  initial begin
    envelope_result_t none;
    logic signed [31:0] slope_now, base, sx;
    int kind, step;
    longint spare;
    none.value = '0; none.status = ST_INSERTED;
    mismatches = 0; hull_count = 0;
    rst_n = 1'b0; start = 1'b0; in_op = OP_INSERT;
    in_slope = '0; in_intercept = '0; in_query_x = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      none.value  = directed_rows[i].value;
      none.status = directed_rows[i].status;
      send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].x, directed_rows[i].fixed, none);
    end

    // lines that never pop each other, but every slope lies below the top line's, so each is refused
    base = -1000000;
    for (int i = 0; i < MAX_LINES + 6; i++)
      send_item(OP_INSERT, base + i, -(i * i), 0, 1'b0, none);
    // probes of the store, some x values at odd offsets
    for (int i = 0; i < 60; i++) begin
      kind = $urandom_range(0, 2);
      sx = (kind == 0) ? $urandom : (kind == 1) ? 2 * $urandom_range(0, 1100) - 1
                                                 : $urandom_range(0, 3000) - 100;
      send_item(OP_QUERY, $urandom, $urandom, sx, 1'b0, none);
    end

    // let the block drain completely before the random part
    while (pending_results.size() != 0) @(posedge clk);

    // random part: slopes climb so that pops and breakpoints keep changing
    slope_now = base + MAX_LINES + 10;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        sx = (kind < 5) ? ((kind & 1) ? S_MAX : S_MIN) : $urandom;
        send_item(OP_QUERY, $urandom, $urandom, sx, 1'b0, none);
      end else if (kind < 52) begin
        // slope below the top line
        send_item(OP_INSERT, slope_now - $urandom_range(1, 1000), $urandom,
                  $urandom, 1'b0, none);
      end else begin
        step = (kind < 60) ? 0 : (kind < 75) ? $urandom_range(1, 100)
                                            : $urandom_range(1, 2400000);
        // headroom kept in 64 bits so it cannot wrap
        spare = longint'(S_MAX) - longint'(slope_now);
        if (longint'(step) > spare) step = int'(spare);
        slope_now = slope_now + step;
        send_item(OP_INSERT, slope_now, $urandom, $urandom, 1'b0, none);
      end
    end
    // steepest possible line, then probes
    send_item(OP_INSERT, S_MAX, S_MAX, 0, 1'b0, none);
    send_item(OP_QUERY, 0, 0, S_MAX, 1'b0, none);
    send_item(OP_QUERY, 0, 0, S_MIN, 1'b0, none);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("PASS upper_envelope_line_max_core");
    else $display("FAIL upper_envelope_line_max_core");
    $finish;
  end

endmodule
